/* src/cgtp_pkg.sv */
package cgtp_pkg;

    // Field widths
    localparam int COORD_W   = 12;
    localparam int CHAN_W    = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W    = 16;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_DIM = 13'd1024;

    // Hue step is never below 2^3
    localparam int HUE_STEP_MIN_LOG = 3;

    // Hue sectors of the HSV wheel
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    // Checker tints: cell size 2^log, add on even / odd cells
    localparam int TINT_LOG_A = 0;
    localparam int TINT_LOG_B = 2;
    localparam int TINT_LOG_C = 5;
    localparam int TINT_LOG_D = 7;
    localparam logic [7:0] TINT_EVEN_A = 8'd7;
    localparam logic [7:0] TINT_EVEN_B = 8'd12;
    localparam logic [7:0] TINT_EVEN_C = 8'd17;
    localparam logic [7:0] TINT_EVEN_D = 8'd38;
    localparam logic [7:0] TINT_ODD_A  = 8'd3;
    localparam logic [7:0] TINT_ODD_B  = 8'd6;
    localparam logic [7:0] TINT_ODD_C  = 8'd8;
    localparam logic [7:0] TINT_ODD_D  = 8'd19;

    // Grid lines every 32 pixels
    localparam int         GRID_LOG = 5;
    localparam logic [7:0] GRID_ADD = 8'd63;

    // Total brightening of a pixel; all adds are positive, so one final
    // saturation equals saturating after each add.
    function automatic logic [7:0] tint_total(input logic [COORD_W-1:0] col,
                                              input logic [COORD_W-1:0] row);
        logic [7:0] sum;
        sum = 8'd0;
        sum = sum + ((col[TINT_LOG_A] ^ row[TINT_LOG_A]) ? TINT_ODD_A : TINT_EVEN_A);
        sum = sum + ((col[TINT_LOG_B] ^ row[TINT_LOG_B]) ? TINT_ODD_B : TINT_EVEN_B);
        sum = sum + ((col[TINT_LOG_C] ^ row[TINT_LOG_C]) ? TINT_ODD_C : TINT_EVEN_C);
        sum = sum + ((col[TINT_LOG_D] ^ row[TINT_LOG_D]) ? TINT_ODD_D : TINT_EVEN_D);
        if (col[GRID_LOG-1:0] == '0 || row[GRID_LOG-1:0] == '0) begin
            sum = sum + GRID_ADD;
        end
        return sum;
    endfunction

endpackage

/* src/cgtp_pix_in_if.sv */
interface cgtp_pix_in_if;
    logic                          valid;
    logic                          ready;
    logic [cgtp_pkg::COORD_W-1:0]  column;
    logic [cgtp_pkg::COORD_W-1:0]  row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

/* src/cgtp_pix_out_if.sv */
interface cgtp_pix_out_if;
    logic                         valid;
    logic                         ready;
    logic [cgtp_pkg::CHAN_W-1:0]  red;
    logic [cgtp_pkg::CHAN_W-1:0]  green;
    logic [cgtp_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* src/color_grid_test_pattern_unit.sv */
// Channel   Dir  Handshake         Fields
// i_pix     in   valid / ready     column[11:0], row[11:0]
// o_pix     out  valid / ready     red[7:0], green[7:0], blue[7:0]
// i_cfg     in   i_cfg_we          i_cfg_idx (0 width, 1 height), i_cfg_data[12:0]
//
// One pixel per clock sustained while o_pix is not stalled; twelve register
// stages. Most of the depth is the hue divide: 28 restoring steps, four per
// stage over seven stages, with the brightness divide running alongside.
// Synchronous active-low reset clears all valid bits and sets both dimensions
// to 1024. Each stage moves on when it is empty or the stage after it moves,
// so bubbles close up and i_pix.ready only drops when all stages hold an item
// and o_pix is stalled.
module color_grid_test_pattern_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cgtp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cgtp_pkg::CFG_W-1:0]      i_cfg_data,
    cgtp_pix_in_if.sink                     i_pix,
    cgtp_pix_out_if.source                  o_pix
);

    localparam int COORD_W = cgtp_pkg::COORD_W;
    localparam int FRAC_W  = cgtp_pkg::FRAC_W;
    localparam int CHAN_W  = cgtp_pkg::CHAN_W;
    localparam int WW      = $clog2(MAX_DIM + 1);
    localparam int HW      = $clog2(10 * MAX_DIM + 1);
    localparam int DW      = $clog2(MAX_DIM + 4 * ((1 << COORD_W) - 1) + 1);
    localparam int HNUM_W  = COORD_W + FRAC_W;
    localparam int SPS     = 4;
    localparam int DS      = HNUM_W / SPS;
    localparam int ST_A    = DS + 1;
    localparam int ST_B    = DS + 2;
    localparam int ST_C    = DS + 3;
    localparam int ST_O    = DS + 4;
    localparam int NST     = DS + 5;

    // Config registers
    logic [cgtp_pkg::CFG_W-1:0] r_width;
    logic [cgtp_pkg::CFG_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cgtp_pkg::RESET_DIM;
            r_height <= cgtp_pkg::RESET_DIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cgtp_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                cgtp_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: valid bits and per-stage advance
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_rdy;
    logic           w_in_acc;
    logic           w_out_acc;

    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || o_pix.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_pix.ready = w_rdy[0];
    assign w_in_acc    = i_pix.valid && w_rdy[0];
    assign w_out_acc   = r_vld[NST-1] && o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: clamp dimensions, quantize column, set up both divides and the tint
    logic [WW-1:0]      w_w_eff;
    logic [WW-1:0]      w_h_eff;
    logic [WW-1:0]      w_q8;
    logic [COORD_W-1:0] w_keep;
    logic [HW-1:0]      w_h10;
    logic [DW-1:0]      w_dnum;

    always_comb begin
        if (r_width == '0) begin
            w_w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_DIM)) begin
            w_w_eff = WW'(MAX_DIM);
        end else begin
            w_w_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            w_h_eff = WW'(1);
        end else if (32'(r_height) > 32'(MAX_DIM)) begin
            w_h_eff = WW'(MAX_DIM);
        end else begin
            w_h_eff = WW'(r_height);
        end
    end

    // Hue step is the smallest power of two >= max(width/8, 8); a column bit
    // survives when its weight is at least that step.
    assign w_q8 = w_w_eff >> 3;

    always_comb begin
        for (int j = 0; j < COORD_W; j++) begin
            w_keep[j] = (j >= cgtp_pkg::HUE_STEP_MIN_LOG) && ((32'd1 << j) >= 32'(w_q8));
        end
    end

    assign w_h10  = HW'({w_h_eff, 3'b000}) + HW'({w_h_eff, 1'b0});
    assign w_dnum = DW'(w_h_eff) + DW'({i_pix.row, 2'b00});

    // Divide stages: index 0 is the capture stage
    logic [COORD_W-1:0] r_colq [DS+1];
    logic [WW-1:0]      r_w    [DS+1];
    logic [WW-1:0]      r_hr   [DS+1];
    logic [FRAC_W-1:0]  r_hq   [DS+1];
    logic [HW-1:0]      r_h10  [DS+1];
    logic [HW-1:0]      r_vr   [DS+1];
    logic [FRAC_W-1:0]  r_vq   [DS+1];
    logic               r_vsat [DS+1];
    logic [7:0]         r_tint [DS+1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_colq[0] <= i_pix.column & w_keep;
            r_w[0]    <= w_w_eff;
            r_hr[0]   <= '0;
            r_hq[0]   <= '0;
            r_h10[0]  <= w_h10;
            r_vr[0]   <= HW'(w_dnum);
            r_vq[0]   <= '0;
            r_vsat[0] <= 32'(w_dnum) >= 32'(w_h10);
            r_tint[0] <= cgtp_pkg::tint_total(i_pix.column, i_pix.row);
        end
    end

    // Each divide stage does four restoring steps of hue = colq*2^16 / W
    // (low 16 quotient bits kept) and, in the first stages, of the
    // brightness fraction (H + 4*row) / (10*H).
    genvar s;
    generate
        for (s = 1; s <= DS; s++) begin : g_div
            logic [WW-1:0]     n_hr;
            logic [FRAC_W-1:0] n_hq;
            logic [HW-1:0]     n_vr;
            logic [FRAC_W-1:0] n_vq;

            always_comb begin
                logic [HNUM_W-1:0] num;
                logic [WW:0]       ht;
                logic [HW:0]       vt;
                num  = {r_colq[s-1], FRAC_W'(0)};
                n_hr = r_hr[s-1];
                n_hq = r_hq[s-1];
                n_vr = r_vr[s-1];
                n_vq = r_vq[s-1];
                for (int t = 0; t < SPS; t++) begin
                    ht = {n_hr, num[HNUM_W-1-((s-1)*SPS+t)]};
                    if (ht >= {1'b0, r_w[s-1]}) begin
                        n_hr = WW'(ht - {1'b0, r_w[s-1]});
                        n_hq = {n_hq[FRAC_W-2:0], 1'b1};
                    end else begin
                        n_hr = WW'(ht);
                        n_hq = {n_hq[FRAC_W-2:0], 1'b0};
                    end
                    if ((s - 1) * SPS + t < FRAC_W) begin
                        vt = {n_vr, 1'b0};
                        if (vt >= {1'b0, r_h10[s-1]}) begin
                            n_vr = HW'(vt - {1'b0, r_h10[s-1]});
                            n_vq = {n_vq[FRAC_W-2:0], 1'b1};
                        end else begin
                            n_vr = HW'(vt);
                            n_vq = {n_vq[FRAC_W-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    r_colq[s] <= r_colq[s-1];
                    r_w[s]    <= r_w[s-1];
                    r_hr[s]   <= n_hr;
                    r_hq[s]   <= n_hq;
                    r_h10[s]  <= r_h10[s-1];
                    r_vr[s]   <= n_vr;
                    r_vq[s]   <= n_vq;
                    r_vsat[s] <= r_vsat[s-1];
                    r_tint[s] <= r_tint[s-1];
                end
            end
        end
    endgenerate

    // Stage A: hue * 6 gives sector and in-sector fraction; value saturates
    logic [FRAC_W+2:0] w_x6;
    logic [2:0]        r_sec_a;
    logic [FRAC_W-1:0] r_f_a;
    logic [FRAC_W-1:0] r_v_a;
    logic [7:0]        r_tint_a;

    assign w_x6 = (FRAC_W+3)'({r_hq[DS], 2'b00}) + (FRAC_W+3)'({r_hq[DS], 1'b0});

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_A]) begin
            r_sec_a  <= w_x6[FRAC_W+2:FRAC_W];
            r_f_a    <= w_x6[FRAC_W-1:0];
            r_v_a    <= r_vsat[DS] ? '1 : r_vq[DS];
            r_tint_a <= r_tint[DS];
        end
    end

    // Stage B: falling and rising ramps
    logic [2*FRAC_W-1:0] w_prod_t;
    logic [2*FRAC_W:0]   w_prod_q;
    logic [2:0]          r_sec_b;
    logic [FRAC_W-1:0]   r_v_b;
    logic [FRAC_W-1:0]   r_cq_b;
    logic [FRAC_W-1:0]   r_ct_b;
    logic [7:0]          r_tint_b;

    assign w_prod_t = (2*FRAC_W)'(r_v_a) * (2*FRAC_W)'(r_f_a);
    assign w_prod_q = (2*FRAC_W+1)'(r_v_a)
                    * (2*FRAC_W+1)'((FRAC_W+1)'(1 << FRAC_W) - {1'b0, r_f_a});

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_B]) begin
            r_sec_b  <= r_sec_a;
            r_v_b    <= r_v_a;
            r_ct_b   <= w_prod_t[2*FRAC_W-1:FRAC_W];
            r_cq_b   <= w_prod_q[2*FRAC_W-1:FRAC_W];
            r_tint_b <= r_tint_a;
        end
    end

    // Stage C: pick channels by sector, scale to bytes (c*255 >> 16)
    logic [FRAC_W-1:0] w_c0;
    logic [FRAC_W-1:0] w_c1;
    logic [FRAC_W-1:0] w_c2;
    logic [CHAN_W-1:0] r_red_c;
    logic [CHAN_W-1:0] r_grn_c;
    logic [CHAN_W-1:0] r_blu_c;
    logic [7:0]        r_tint_c;

    always_comb begin
        case (r_sec_b)
            cgtp_pkg::SEC_RED_YEL: begin w_c0 = r_v_b;  w_c1 = r_ct_b; w_c2 = '0;     end
            cgtp_pkg::SEC_YEL_GRN: begin w_c0 = r_cq_b; w_c1 = r_v_b;  w_c2 = '0;     end
            cgtp_pkg::SEC_GRN_CYN: begin w_c0 = '0;     w_c1 = r_v_b;  w_c2 = r_ct_b; end
            cgtp_pkg::SEC_CYN_BLU: begin w_c0 = '0;     w_c1 = r_cq_b; w_c2 = r_v_b;  end
            cgtp_pkg::SEC_BLU_MAG: begin w_c0 = r_ct_b; w_c1 = '0;     w_c2 = r_v_b;  end
            default:               begin w_c0 = r_v_b;  w_c1 = '0;     w_c2 = r_cq_b; end
        endcase
    end

    function automatic logic [CHAN_W-1:0] to_byte(input logic [FRAC_W-1:0] c);
        logic [FRAC_W+CHAN_W-1:0] p;
        p = {c, CHAN_W'(0)} - (FRAC_W+CHAN_W)'(c);
        return p[FRAC_W+CHAN_W-1:FRAC_W];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_C]) begin
            r_red_c  <= to_byte(w_c0);
            r_grn_c  <= to_byte(w_c1);
            r_blu_c  <= to_byte(w_c2);
            r_tint_c <= r_tint_b;
        end
    end

    // Output stage: add tints and grid, saturate at 255
    function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                  input logic [7:0]        b);
        logic [CHAN_W:0] sum;
        sum = (CHAN_W+1)'(a) + (CHAN_W+1)'(b);
        return sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
    endfunction

    logic [CHAN_W-1:0] r_red_o;
    logic [CHAN_W-1:0] r_grn_o;
    logic [CHAN_W-1:0] r_blu_o;

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_O]) begin
            r_red_o <= sat_add(r_red_c, r_tint_c);
            r_grn_o <= sat_add(r_grn_c, r_tint_c);
            r_blu_o <= sat_add(r_blu_c, r_tint_c);
        end
    end

    assign o_pix.valid = r_vld[ST_O];
    assign o_pix.red   = r_red_o;
    assign o_pix.green = r_grn_o;
    assign o_pix.blue  = r_blu_o;

    // Items in flight change only by accepts and deliveries
    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_vld) == $past($countones(r_vld))
            + ($past(w_in_acc) ? 1 : 0) - ($past(w_out_acc) ? 1 : 0))
        else $error("pipeline lost or duplicated an item");

    // Back-pressure reaches the input only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_rdy[0] |-> &r_vld)
        else $error("input stalled with a bubble in the pipeline");

    // Hue below 1.0 always gives a sector of at most five
    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_B] |-> (r_sec_b <= cgtp_pkg::SEC_MAG_RED))
        else $error("hue sector out of range");

endmodule
